@@ rtl/core/ncfq_pkg.sv @@
// shared types, widths and arctangent constants for the normal cube face quantizer
`timescale 1ns / 1ps
package ncfq_pkg;

  localparam int unsigned CompBits   = 16;
  localparam int unsigned GuardBits  = 24;
  localparam int unsigned CordicBits = CompBits + GuardBits + 3;
  localparam int unsigned AngleBits  = 33;
  localparam int unsigned TableLen   = 24;
  localparam int unsigned IndexBits  = 14;
  localparam int unsigned FaceBits   = 3;
  localparam logic [24:0] FourOverPiQ24 = 25'd21361415;

  // default geometry of the cube map and cordic depth
  localparam int unsigned BinsPerAxisDefault     = 52;
  localparam int unsigned AngleIterationsDefault = 16;

  typedef struct packed {
    logic signed [CompBits-1:0] comp_x;
    logic signed [CompBits-1:0] comp_y;
    logic signed [CompBits-1:0] comp_z;
  } in_beat_t;

  typedef struct packed {
    logic [IndexBits-1:0] bin_index;
    logic                 no_normal;
  } out_beat_t;

  typedef struct packed {
    logic signed [CordicBits-1:0] x;
    logic signed [CordicBits-1:0] y;
    logic signed [AngleBits-1:0]  z;
  } vec_t;

  // both angles of one normal plus the face it lands on
  typedef struct packed {
    vec_t                lo;
    vec_t                hi;
    logic [FaceBits-1:0] face;
    logic                no_normal;
  } cordic_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // one vectoring rotation, floor shifts
  function automatic vec_t cordic_rot(input vec_t v, input logic [4:0] step);
    logic signed [CordicBits-1:0] dx;
    logic signed [CordicBits-1:0] dy;
    logic signed [AngleBits-1:0]  a;
    vec_t r;
    dx = v.x >>> step;
    dy = v.y >>> step;
    a  = $signed({1'b0, atan_q30(step)});
    if (!v.y[CordicBits-1]) begin
      r.x = v.x + dy;
      r.y = v.y - dx;
      r.z = v.z + a;
    end else begin
      r.x = v.x - dy;
      r.y = v.y + dx;
      r.z = v.z - a;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ncfq_cell.sv @@
// one cordic vectoring cell, rotates both minor angles by one step
`timescale 1ns / 1ps
module ncfq_cell import ncfq_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  cordic_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output cordic_t data_o
);

  localparam logic [4:0] StepIdx = 5'(Step);

  logic    valid_q;
  cordic_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d    = data_i;
    data_d.lo = cordic_rot(data_i.lo, StepIdx);
    data_d.hi = cordic_rot(data_i.hi, StepIdx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/core/ncfq_bin.sv @@
// angle to bin scaling, rounding, clamping and final index assembly
`timescale 1ns / 1ps
module ncfq_bin import ncfq_pkg::*; #(
  parameter int unsigned BinsPerAxis = BinsPerAxisDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cordic_t   data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output out_beat_t data_o
);

  localparam int unsigned BW = (BinsPerAxis > 1) ? $clog2(BinsPerAxis) : 1;
  localparam int unsigned IW = 20;
  localparam logic signed [47:0] Offset = 48'(5 * (BinsPerAxis - 1)) << 30;
  localparam logic signed [47:0] Half   = 48'(5) << 30;
  localparam logic signed [12:0] Gain   = 13'(5 * BinsPerAxis - 1);
  localparam logic [12:0] MaxBin = 13'(BinsPerAxis - 1);
  localparam logic [IW-1:0] FaceSize = IW'(BinsPerAxis * BinsPerAxis);
  localparam logic [IW-1:0] Bins = IW'(BinsPerAxis);

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;
  assign r4 = !v4_q || ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;

  logic [FaceBits-1:0] face1_q, face2_q, face3_q;
  logic                nn1_q, nn2_q, nn3_q;

  // stage 1: angle in units of pi/4
  logic signed [58:0] plo, phi;
  logic signed [33:0] tlo_q, thi_q;
  assign plo = $signed({{26{data_i.lo.z[AngleBits-1]}}, data_i.lo.z})
             * $signed({34'd0, FourOverPiQ24});
  assign phi = $signed({{26{data_i.hi.z[AngleBits-1]}}, data_i.hi.z})
             * $signed({34'd0, FourOverPiQ24});

  // stage 2: bin value, product truncated to 48 bits
  logic signed [47:0] vlo_q, vhi_q;
  logic signed [47:0] vlo_d, vhi_d;
  assign vlo_d = Offset + 48'($signed({{14{tlo_q[33]}}, tlo_q}) * Gain);
  assign vhi_d = Offset + 48'($signed({{14{thi_q[33]}}, thi_q}) * Gain);

  // stage 3: round half away, divide by ten by reciprocal, clamp
  function automatic logic [BW-1:0] to_bin(input logic signed [47:0] v);
    logic signed [47:0] a;
    logic [15:0] n;
    logic [31:0] p;
    logic [12:0] q;
    logic [BW-1:0] b;
    a = v + Half;
    n = a[45:30];
    p = {16'd0, n} * 32'd52429;
    q = p[31:19];
    if (v[47]) b = '0;
    else if (q > MaxBin) b = BW'(MaxBin);
    else b = BW'(q);
    return b;
  endfunction

  logic [BW-1:0] col_q, row_q;

  // stage 4: index
  logic [IW-1:0] idx_d;
  always_comb begin
    if (nn3_q) idx_d = IW'(6) * FaceSize;
    else idx_d = IW'(face3_q) * FaceSize + IW'(col_q) + Bins * IW'(row_q);
  end

  out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      tlo_q   <= plo[57:24];
      thi_q   <= phi[57:24];
      face1_q <= data_i.face;
      nn1_q   <= data_i.no_normal;
    end
    if (r2 && v1_q) begin
      vlo_q   <= vlo_d;
      vhi_q   <= vhi_d;
      face2_q <= face1_q;
      nn2_q   <= nn1_q;
    end
    if (r3 && v2_q) begin
      col_q   <= to_bin(vlo_q);
      row_q   <= to_bin(vhi_q);
      face3_q <= face2_q;
      nn3_q   <= nn2_q;
    end
    if (r4 && v3_q) begin
      out_q.bin_index <= idx_d[IndexBits-1:0];
      out_q.no_normal <= nn3_q;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = out_q;

endmodule

@@ rtl/core/normal_cube_face_quantizer_unit.sv @@
// top level of the normal cube face quantizer: face select, cordic cell row, bin stage
`timescale 1ns / 1ps
// usage
//   in channel: in_valid_i / in_ready_o carry one normal per beat (signed q1.15
//   x, y, z). out channel: out_valid_o / out_ready_i carry the bin index and the
//   no-normal flag, one result beat per input beat, in order
//   stages: 1 face select stage, one stage per cordic cell and 4 scale/round/index
//   stages, from input beat to output valid
//   throughput: one beat per cycle while out_ready_i stays high; every stage is a
//   register with its own valid, so the row length sets only the latency, never the rate
//   stall: each stage holds while its successor is full, bubbles collapse, and
//   in_ready_o drops only once every stage up to the input holds a beat
//   reset: rst_ni clears all stage valids, no beats are in flight afterwards
//   face order: +x, -x, +y, -y, +z, -z; an all-zero normal gives index
//   6*bins*bins with no_normal set
module normal_cube_face_quantizer_unit import ncfq_pkg::*; #(
  parameter int unsigned BinsPerAxis     = BinsPerAxisDefault,
  parameter int unsigned AngleIterations = AngleIterationsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  // face select: magnitudes, strict compares, sign of the dominant axis
  logic [CompBits:0] ax, ay, az;
  assign ax = in_beat_i.comp_x[CompBits-1]
            ? (CompBits+1)'(-$signed({in_beat_i.comp_x[CompBits-1], in_beat_i.comp_x}))
            : {1'b0, in_beat_i.comp_x};
  assign ay = in_beat_i.comp_y[CompBits-1]
            ? (CompBits+1)'(-$signed({in_beat_i.comp_y[CompBits-1], in_beat_i.comp_y}))
            : {1'b0, in_beat_i.comp_y};
  assign az = in_beat_i.comp_z[CompBits-1]
            ? (CompBits+1)'(-$signed({in_beat_i.comp_z[CompBits-1], in_beat_i.comp_z}))
            : {1'b0, in_beat_i.comp_z};

  cordic_t sel_d, sel_q;
  logic    sel_valid_q, sel_ready;
  logic [1:0] axis;
  logic signed [CompBits-1:0] lo, hi, sd;
  logic [CompBits:0] dom;

  always_comb begin
    if (ax > ay) axis = (az > ax) ? 2'd2 : 2'd0;
    else axis = (az > ay) ? 2'd2 : 2'd1;
    case (axis)
      2'd0: begin
        lo = in_beat_i.comp_y; hi = in_beat_i.comp_z; sd = in_beat_i.comp_x; dom = ax;
      end
      2'd1: begin
        lo = in_beat_i.comp_x; hi = in_beat_i.comp_z; sd = in_beat_i.comp_y; dom = ay;
      end
      default: begin
        lo = in_beat_i.comp_x; hi = in_beat_i.comp_y; sd = in_beat_i.comp_z; dom = az;
      end
    endcase
    // cordic operands carry the guard bits below the component
    sel_d.lo.x = {2'b00, dom, {GuardBits{1'b0}}};
    sel_d.lo.y = {{3{lo[CompBits-1]}}, lo, {GuardBits{1'b0}}};
    sel_d.lo.z = '0;
    sel_d.hi.x = {2'b00, dom, {GuardBits{1'b0}}};
    sel_d.hi.y = {{3{hi[CompBits-1]}}, hi, {GuardBits{1'b0}}};
    sel_d.hi.z = '0;
    sel_d.face = {axis, sd[CompBits-1]};
    sel_d.no_normal = (in_beat_i.comp_x == '0) && (in_beat_i.comp_y == '0)
                   && (in_beat_i.comp_z == '0);
  end

  assign in_ready_o = !sel_valid_q || sel_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      sel_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sel_q <= sel_d;
    end
  end

  // row of cordic cells, cell k applies rotation k
  logic    cv [AngleIterations+1];
  logic    cr [AngleIterations+1];
  cordic_t cd [AngleIterations+1];

  assign cv[0]     = sel_valid_q;
  assign cd[0]     = sel_q;
  assign sel_ready = cr[0];

  for (genvar k = 0; k < AngleIterations; k++) begin : g_cell
    ncfq_cell #(
      .Step (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .ready_o (cr[k]),
      .data_i  (cd[k]),
      .valid_o (cv[k+1]),
      .ready_i (cr[k+1]),
      .data_o  (cd[k+1])
    );
  end

  ncfq_bin #(
    .BinsPerAxis (BinsPerAxis)
  ) u_bin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv[AngleIterations]),
    .ready_o (cr[AngleIterations]),
    .data_i  (cd[AngleIterations]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_beat_o)
  );

  // an empty normal always reports the no-normal index
  localparam logic [IndexBits-1:0] NoNormalIdx = IndexBits'(6 * BinsPerAxis * BinsPerAxis);

  a_no_normal_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.no_normal |-> out_beat_o.bin_index == NoNormalIdx)
    else $error("no-normal beat with wrong index");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

  a_zero_in_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && sel_d.no_normal |=> sel_valid_q && sel_q.no_normal)
    else $error("all-zero normal lost its flag in face select");

endmodule
